### src/sfcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame CRC check and decode: shared package
// Frame positions, CRC constants, item and result types and the byte-wide
// CRC-16 update used by the decoder.
// ----------------------------------------------------------------------------
package sfcc_pkg;

	localparam int unsigned IdxW = 4;

	// Byte positions within the eight-byte response frame.
	localparam logic [IdxW-1:0] IDX_FUNC     = 4'd0;
	localparam logic [IdxW-1:0] IDX_HUM_HI   = 4'd2;
	localparam logic [IdxW-1:0] IDX_HUM_LO   = 4'd3;
	localparam logic [IdxW-1:0] IDX_TEMP_HI  = 4'd4;
	localparam logic [IdxW-1:0] IDX_TEMP_LO  = 4'd5;
	localparam logic [IdxW-1:0] IDX_CRC_SPAN = 4'd6;
	localparam logic [IdxW-1:0] IDX_CRC_LO   = 4'd6;
	localparam logic [IdxW-1:0] IDX_CRC_HI   = 4'd7;
	localparam logic [IdxW-1:0] IDX_IDLE     = 4'd8;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} sfcc_item_t;

	typedef struct packed {
		logic              crc_ok;
		logic [15:0]       humidity_tenths;
		logic signed [15:0] temperature_tenths;
	} sfcc_result_t;

	// Modbus CRC-16, reflected, one byte shifted in LSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage : sfcc_pkg
`default_nettype wire

### src/sensor_frame_crc_check_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame CRC check and decode: top level
// Input register, frame decoder and result register for eight-byte sensor
// response frames checked with a Modbus CRC-16.
// ----------------------------------------------------------------------------
// Bytes enter one item per cycle; each accepted byte is registered, processed
// by the decoder (including a full byte-wide CRC update) when it fires, and
// the eighth byte of a frame then writes one result into the output register.
// A new byte is taken while a result waits; only a frame-ending byte stalls,
// and only while the previous result still sits unread in the output register.
// ----------------------------------------------------------------------------
module sensor_frame_crc_check_decode
	import sfcc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         frame_start,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic              crc_ok,
	output logic [15:0]       humidity_tenths,
	output logic signed [15:0] temperature_tenths
);

	logic         valid_s1;
	sfcc_item_t   item_s1;
	logic         out_valid_q;
	sfcc_result_t result_q;

	logic         res_valid;
	sfcc_result_t res;
	logic         out_free;
	logic         fire;

	assign out_free = !out_valid_q || out_ready;
	assign fire     = valid_s1 && (!res_valid || out_free);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.rx_byte     <= rx_byte;
			item_s1.frame_start <= frame_start;
		end
	end

	sfcc_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.fire       (fire),
		.item       (item_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			result_q <= res;
		end
	end

	assign out_valid          = out_valid_q;
	assign crc_ok             = result_q.crc_ok;
	assign humidity_tenths    = result_q.humidity_tenths;
	assign temperature_tenths = result_q.temperature_tenths;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(fire && res_valid))
		else $error("unread result overwritten");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(result_q))
		else $error("waiting result changed");

	a_stall_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |-> res_valid && out_valid_q && !out_ready)
		else $error("input stage stalled without cause");

endmodule : sensor_frame_crc_check_decode
`default_nettype wire

### src/sfcc_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame CRC check and decode: frame state and decode logic
// Holds the frame position, running CRC and captured words, and forms the
// result for the last byte of a frame. State advances when the item fires.
// ----------------------------------------------------------------------------
module sfcc_decode
	import sfcc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	input  wire logic         fire,
	input  wire sfcc_item_t   item,
	output logic              res_valid,
	output sfcc_result_t      res
);

	logic [IdxW-1:0] byte_index_q;
	logic [15:0]     running_crc_q;
	logic [15:0]     humidity_word_q;
	logic [15:0]     temperature_word_q;
	logic [7:0]      crc_first_byte_q;

	logic [IdxW-1:0] idx;
	logic [15:0]     crc_base;
	logic            active;
	logic [15:0]     received;
	logic [14:0]     mag;
	logic            ok;

	always_comb begin
		if (item.frame_start) begin
			idx      = IDX_FUNC;
			crc_base = CRC_INIT;
		end else begin
			idx      = byte_index_q;
			crc_base = running_crc_q;
		end
	end

	// A byte without a start flag while idle is dropped.
	assign active    = item.frame_start || (byte_index_q < IDX_IDLE);
	assign res_valid = item_valid && active && (idx == IDX_CRC_HI);

	assign received = {item.rx_byte, crc_first_byte_q};
	assign ok       = (received == running_crc_q);
	assign mag      = temperature_word_q[14:0];

	always_comb begin
		res.crc_ok             = ok;
		res.humidity_tenths    = '0;
		res.temperature_tenths = '0;
		if (ok) begin
			res.humidity_tenths = humidity_word_q;
			if (temperature_word_q[15]) begin
				res.temperature_tenths = -$signed({1'b0, mag});
			end else begin
				res.temperature_tenths = $signed({1'b0, mag});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q       <= IDX_IDLE;
			running_crc_q      <= CRC_INIT;
			humidity_word_q    <= '0;
			temperature_word_q <= '0;
			crc_first_byte_q   <= '0;
		end else if (fire && active) begin
			if (idx < IDX_CRC_SPAN) begin
				running_crc_q <= crc16_byte(crc_base, item.rx_byte);
			end else begin
				running_crc_q <= crc_base;
			end
			unique case (idx)
				IDX_HUM_HI:  humidity_word_q    <= {item.rx_byte, 8'h00};
				IDX_HUM_LO:  humidity_word_q    <= {humidity_word_q[15:8], item.rx_byte};
				IDX_TEMP_HI: temperature_word_q <= {item.rx_byte, 8'h00};
				IDX_TEMP_LO: temperature_word_q <= {temperature_word_q[15:8], item.rx_byte};
				IDX_CRC_LO:  crc_first_byte_q   <= item.rx_byte;
				default: ;
			endcase
			if (idx == IDX_CRC_HI) begin
				byte_index_q <= IDX_IDLE;
			end else begin
				byte_index_q <= idx + 4'd1;
			end
		end
	end

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= IDX_IDLE)
		else $error("frame position out of range");

	a_result_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid |=> byte_index_q == IDX_IDLE)
		else $error("frame did not return to idle after its result");

	a_fail_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.crc_ok |->
		res.humidity_tenths == 16'h0000 && res.temperature_tenths == 16'sh0000)
		else $error("failed frame carries nonzero values");

	a_start_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item.frame_start |-> !res_valid)
		else $error("start byte produced a result");

endmodule : sfcc_decode
`default_nettype wire
